### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue: result status
// codes, datapath operations and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package spq_pkg;

    // result status field
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // request kind carried on the input tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    // operation the datapath carries out in the execute step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_POP,
        OP_REJECT_FULL,
        OP_REJECT_EMPTY
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch the incoming request
        t_op  op;       // operation to execute this cycle
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;   // held request is a pop
        logic empty;    // no entries stored
        logic full;     // all slots in use
    } t_dp_sts;

endpackage

### rtl/core/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Timing: a request is captured at the accepting edge, then executed once the
//   result register is free, which loads the result and raises its valid.
// A new request is accepted only after the held one has executed; the sorted
//   slot row compares all slots in parallel in the execute step.
// Reset (synchronous, active low) empties the queue and clears both
//   handshakes; slot contents are not cleared, only slots below the count are read.
// Bounded stable priority queue: inserts go ahead of the first entry of
// strictly lower priority; pops return the head.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: command_priority, command_payload (low to high), zero filled
    input  logic [((PRIORITY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: mode
    input  logic                   s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: popped_priority, popped_payload, occupancy (low to high), zero filled
    output logic [((PRIORITY_WIDTH + PAYLOAD_WIDTH + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                   m_axis_tdata,
    // tuser: status
    output logic [spq_pkg::STATUS_W-1:0] m_axis_tuser
);

    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_BITS    = PRIORITY_WIDTH + PAYLOAD_WIDTH + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    spq_pkg::t_dp_cmd            w_cmd;
    spq_pkg::t_dp_sts            w_sts;
    logic [PRIORITY_WIDTH-1:0]   w_pop_pri;
    logic [PAYLOAD_WIDTH-1:0]    w_pop_pay;
    logic [OCC_W-1:0]            w_occ;

    // sequencer
    spq_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // slot row and result register
    spq_datapath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH),
        .OCC_W          (OCC_W)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_mode            (s_axis_tuser),
        .i_priority        (s_axis_tdata[PRIORITY_WIDTH-1:0]),
        .i_payload         (s_axis_tdata[PRIORITY_WIDTH +: PAYLOAD_WIDTH]),
        .o_sts             (w_sts),
        .o_status          (m_axis_tuser),
        .o_popped_priority (w_pop_pri),
        .o_popped_payload  (w_pop_pay),
        .o_occupancy       (w_occ)
    );

    // pack result fields
    assign m_axis_tdata = OUT_TDATA_W'({w_occ, w_pop_pay, w_pop_pri});

endmodule

### rtl/core/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted entry slots (head in slot 0) with a per-slot priority
// compare, the held request and the result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int PAYLOAD_WIDTH  = 32,
    parameter int PRIORITY_WIDTH = 8,
    parameter int OCC_W          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spq_pkg::t_dp_cmd            i_cmd,
    input  logic                        i_mode,
    input  logic [PRIORITY_WIDTH-1:0]   i_priority,
    input  logic [PAYLOAD_WIDTH-1:0]    i_payload,
    output spq_pkg::t_dp_sts            o_sts,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output logic [PRIORITY_WIDTH-1:0]   o_popped_priority,
    output logic [PAYLOAD_WIDTH-1:0]    o_popped_payload,
    output logic [OCC_W-1:0]            o_occupancy
);

    // held request
    logic                        r_mode;
    logic [PRIORITY_WIDTH-1:0]   r_pri;
    logic [PAYLOAD_WIDTH-1:0]    r_pay;

    // entry slots and fill count
    logic [PRIORITY_WIDTH-1:0]   r_ent_pri [QUEUE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0]    r_ent_pay [QUEUE_DEPTH];
    logic [OCC_W-1:0]            r_count;
    logic [OCC_W-1:0]            n_count;

    // result register
    logic [spq_pkg::STATUS_W-1:0] r_status;
    logic [PRIORITY_WIDTH-1:0]   r_pop_pri;
    logic [PAYLOAD_WIDTH-1:0]    r_pop_pay;

    // slot i is at or after the insert point (monotone over the sorted row)
    logic [QUEUE_DEPTH-1:0]      w_mark;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_mark[i] = (OCC_W'(i) >= r_count) || (r_pri > r_ent_pri[i]);
        end
    end

    // status back to the controller
    assign o_sts.is_pop = (r_mode == spq_pkg::MODE_POP);
    assign o_sts.empty  = (r_count == '0);
    assign o_sts.full   = (r_count == OCC_W'(QUEUE_DEPTH));

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_pri  <= i_priority;
            r_pay  <= i_payload;
        end
    end

    // slot row: shift right behind the insert point, shift left on pop
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
        logic w_first;
        if (g == 0) begin : g_head
            assign w_first = w_mark[0];
        end else begin : g_body
            assign w_first = w_mark[g] && !w_mark[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.op == spq_pkg::OP_INSERT) begin
                if (w_first) begin
                    r_ent_pri[g] <= r_pri;
                    r_ent_pay[g] <= r_pay;
                end else if (w_mark[g]) begin
                    if (g > 0) begin
                        r_ent_pri[g] <= r_ent_pri[(g > 0) ? g - 1 : 0];
                        r_ent_pay[g] <= r_ent_pay[(g > 0) ? g - 1 : 0];
                    end
                end
            end else if (i_cmd.op == spq_pkg::OP_POP) begin
                if (g < QUEUE_DEPTH - 1) begin
                    r_ent_pri[g] <= r_ent_pri[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    r_ent_pay[g] <= r_ent_pay[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    end

    // fill count
    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            spq_pkg::OP_INSERT: n_count = r_count + OCC_W'(1);
            spq_pkg::OP_POP:    n_count = r_count - OCC_W'(1);
            default:            n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register, loaded on every executed request
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            spq_pkg::OP_INSERT: begin
                r_status  <= spq_pkg::STATUS_OK;
                r_pop_pri <= '0;
                r_pop_pay <= '0;
            end
            spq_pkg::OP_POP: begin
                r_status  <= spq_pkg::STATUS_OK;
                r_pop_pri <= r_ent_pri[0];
                r_pop_pay <= r_ent_pay[0];
            end
            spq_pkg::OP_REJECT_FULL: begin
                r_status  <= spq_pkg::STATUS_FULL;
                r_pop_pri <= '0;
                r_pop_pay <= '0;
            end
            spq_pkg::OP_REJECT_EMPTY: begin
                r_status  <= spq_pkg::STATUS_EMPTY;
                r_pop_pri <= '0;
                r_pop_pay <= '0;
            end
            default: begin
                r_status  <= r_status;
            end
        endcase
    end

    // count only moves on execute, which is when the result register loads
    assign o_status          = r_status;
    assign o_popped_priority = r_pop_pri;
    assign o_popped_payload  = r_pop_pay;
    assign o_occupancy       = r_count;

endmodule

### rtl/core/spq_controller.sv
// ----------------------------------------------------------------------------
// spq_controller
// Two-state sequencer: take a request, then execute it once the result
// register is free; owns both stream handshakes.
// ----------------------------------------------------------------------------
module spq_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  spq_pkg::t_dp_sts i_sts,
    output spq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // command decode
    always_comb begin
        o_cmd.capture = w_accept;
        o_cmd.op      = spq_pkg::OP_NONE;
        if (r_state == S_EXEC && w_out_free) begin
            if (i_sts.is_pop) begin
                o_cmd.op = i_sts.empty ? spq_pkg::OP_REJECT_EMPTY : spq_pkg::OP_POP;
            end else begin
                o_cmd.op = i_sts.full ? spq_pkg::OP_REJECT_FULL : spq_pkg::OP_INSERT;
            end
        end
    end

    // next state and result valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // an accepted request always moves the sequencer into execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // every executed request produces a result
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op != spq_pkg::OP_NONE) |=> r_out_valid)
        else $error("executed request left no result");

    // datapath never reports empty and full together
    a_sts_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_sts.empty && i_sts.full))
        else $error("datapath reports empty and full at once");

    // no execution while an untaken result would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> (o_cmd.op == spq_pkg::OP_NONE))
        else $error("result overwritten before it was taken");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stable priority queue. A shadow queue in the
// scoreboard predicts status, popped entry and occupancy for each accepted
// request. Results are compared in order with that prediction. Stimulus is a
// directed fill/overflow/drain pass, then random insert/pop mixes with random
// idling on both streams, a long result hold-off and a full drain midway.
// ----------------------------------------------------------------------------

// one predicted result
typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [31:0] payload;
    logic [4:0]  occupancy;
} t_pq_result;

// shadow queue plus in-order result checker
class pq_scoreboard;
    localparam int DEPTH = 16;

    logic [7:0]  slot_prio [DEPTH];
    logic [31:0] slot_pay  [DEPTH];
    int          count;
    t_pq_result  pending[$];
    int          errors;
    int          checked;
    int          n_insert;
    int          n_full;
    int          n_pop;
    int          n_empty;

    function new();
        count    = 0;
        errors   = 0;
        checked  = 0;
        n_insert = 0;
        n_full   = 0;
        n_pop    = 0;
        n_empty  = 0;
    endfunction

    // apply one accepted request to the shadow queue, queue its result
    function void note_request(logic mode, logic [7:0] prio, logic [31:0] payload);
        t_pq_result r;
        int         pos;
        r = '0;
        if (mode == spq_pkg::MODE_INSERT) begin
            if (count >= DEPTH) begin
                r.status = spq_pkg::STATUS_FULL;
                n_full++;
            end else begin
                // stable: land ahead of the first strictly lower priority
                pos = count;
                for (int i = 0; i < count; i++) begin
                    if (pos == count && prio > slot_prio[i]) pos = i;
                end
                for (int i = count; i > pos; i--) begin
                    slot_prio[i] = slot_prio[i-1];
                    slot_pay[i]  = slot_pay[i-1];
                end
                slot_prio[pos] = prio;
                slot_pay[pos]  = payload;
                count++;
                r.status = spq_pkg::STATUS_OK;
                n_insert++;
            end
        end else begin
            if (count == 0) begin
                r.status = spq_pkg::STATUS_EMPTY;
                n_empty++;
            end else begin
                r.status  = spq_pkg::STATUS_OK;
                r.prio    = slot_prio[0];
                r.payload = slot_pay[0];
                for (int i = 1; i < count; i++) begin
                    slot_prio[i-1] = slot_prio[i];
                    slot_pay[i-1]  = slot_pay[i];
                end
                count--;
                n_pop++;
            end
        end
        r.occupancy = count[4:0];
        pending.insert(pending.size(), r);
    endfunction

    // compare one accepted result against the oldest prediction
    function void check_result(logic [1:0] status, logic [7:0] prio,
                               logic [31:0] payload, logic [4:0] occupancy);
        t_pq_result want;
        if (pending.size() == 0) begin
            $error("result with no request outstanding: status %0d", status);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
        end
        if (prio !== want.prio) begin
            $error("popped_priority: expected %0d, got %0d", want.prio, prio);
            errors++;
        end
        if (payload !== want.payload) begin
            $error("popped_payload: expected %h, got %h", want.payload, payload);
            errors++;
        end
        if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int S_W        = 40;    // priority[7:0], payload[39:8]
    localparam int M_W        = 48;    // priority[7:0], payload[39:8], occupancy[44:40]
    localparam int N_RANDOM   = 1100;
    localparam int IDLE_LIMIT = 3000;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata;   // command_priority, command_payload (low to high)
    logic           s_axis_tuser;   // mode
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [M_W-1:0] m_axis_tdata;   // popped_priority, popped_payload, occupancy
    logic [1:0]     m_axis_tuser;   // status

    pq_scoreboard   sb;
    int             items_sent;
    bit             calm;           // no idling on either side
    int             idle_cycles = 0;

    stable_priority_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offer one request, with a random gap ahead of it
    task automatic send_request(logic mode, logic [7:0] prio, logic [31:0] payload);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 16) gap++;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {payload, prio};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(mode, prio, payload);
        items_sent++;
        calm = (items_sent >= 700 && items_sent < 900);
    endtask

    // drop valid and hold until every outstanding result is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // random priority, weighted toward ties and extremes
    function automatic logic [7:0] pick_prio();
        logic [7:0] p;
        case ($urandom_range(9)) inside
            [0:3]:   p = 8'($urandom_range(3));
            4:       p = 8'($urandom_range(255, 252));
            5:       p = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            default: p = 8'($urandom_range(255));
        endcase
        return p;
    endfunction

    // receiver ready: random idling, one long hold-off
    initial begin
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sb != null && sb.checked >= 300) begin
                m_axis_tready = 1'b0;
                repeat (250) @(negedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready = calm || ($urandom_range(99) >= 16);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                            m_axis_tdata[44:40]);
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        logic [7:0] fill_prio [9];
        int         ins_pct;
        logic       mode;

        sb            = new();
        items_sent    = 0;
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = spq_pkg::MODE_INSERT;
        fill_prio     = '{8'd1, 8'd254, 8'd127, 8'd129, 8'd64, 8'd200, 8'd128,
                          8'd3, 8'd255};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pop, extremes, ties, fill to full, overflow, partial drain
        send_request(spq_pkg::MODE_POP, 8'hFF, 32'hFFFF_FFFF);
        send_request(spq_pkg::MODE_INSERT, 8'd255, 32'h0000_0000);
        send_request(spq_pkg::MODE_INSERT, 8'd0, 32'hFFFF_FFFF);
        send_request(spq_pkg::MODE_INSERT, 8'd128, 32'h0000_0001);
        send_request(spq_pkg::MODE_INSERT, 8'd128, 32'h0000_0002);
        send_request(spq_pkg::MODE_INSERT, 8'd128, 32'h0000_0003);
        send_request(spq_pkg::MODE_INSERT, 8'd255, 32'hA5A5_A5A5);
        send_request(spq_pkg::MODE_INSERT, 8'd0, 32'h5A5A_5A5A);
        foreach (fill_prio[i]) send_request(spq_pkg::MODE_INSERT, fill_prio[i], $urandom);
        send_request(spq_pkg::MODE_INSERT, 8'd255, 32'hDEAD_BEEF);
        repeat (6) send_request(spq_pkg::MODE_POP, 8'h00, 32'h0000_0000);
        wait_drained();

        // random mixes, insert share changes every 64 requests
        ins_pct = 50;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(2))
                    0:       ins_pct = 85;
                    1:       ins_pct = 50;
                    default: ins_pct = 20;
                endcase
            end
            if (n == 550) wait_drained();
            mode = ($urandom_range(99) < ins_pct) ? spq_pkg::MODE_INSERT : spq_pkg::MODE_POP;
            send_request(mode, pick_prio(), $urandom);
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests: %0d inserts, %0d refused as full,",
                 items_sent, sb.n_insert, sb.n_full);
        $display("  %0d pops, %0d pops on empty, %0d results checked",
                 sb.n_pop, sb.n_empty, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
